// ===== design/mlp_pkg.sv =====
// ---------------------------------------------------------------------------
// mlp_pkg: shared types and constants for the 2-3-1 perceptron unit
// Fixed-point formats, the micro-op codes that the sequencer sends to the
// datapath, the sigmoid table and the reset weights.
// ---------------------------------------------------------------------------
`default_nettype none

package mlp_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int SIG_ENTRIES = 256;
    localparam int SIG_IDX_W   = $clog2(SIG_ENTRIES);
    // The clamped argument spans 16.0, that is FRAC_BITS + 4 bits.
    localparam int SIG_SPAN_W  = FRAC_BITS + 4;
    localparam int SIG_FRAC_W  = SIG_SPAN_W - SIG_IDX_W;
    localparam int ROM_W       = FRAC_BITS + 1;

    localparam int W_W    = 32;  // weight width
    localparam int NET_W  = 41;  // hidden net sum
    localparam int O_W    = 36;  // output net sum
    localparam int OP_W   = 33;  // multiplier operand width
    localparam int PROD_W = 2 * OP_W;
    localparam int ACC_W  = 40;  // weight update sum before saturation
    localparam int ERR_W  = 18;
    localparam int DOUT_W = 20;
    localparam int STEP_W = 5;

    localparam longint Q30    = 64'sd1 << 30;
    localparam longint ONE_FX = 64'sd1 << FRAC_BITS;

    typedef logic [ROM_W-1:0] sig_rom_t [0:SIG_ENTRIES];

    typedef enum logic [3:0] {
        M_NONE,
        M_A_HW,
        M_B_HW,
        M_ACT_OW,
        M_SLOPE_O,
        M_SLOPE_ERR,
        M_ACT_SL,
        M_DOUT_OW,
        M_T_SL,
        M_DH_A,
        M_DH_B,
        M_DOUT_ACT
    } mul_op_t;

    typedef enum logic [3:0] {
        W_NONE,
        W_NET_SET,
        W_NET_ADD,
        W_O_SET,
        W_O_ADD,
        W_SLOPE_O,
        W_SLH,
        W_DOUT,
        W_T,
        W_DH,
        W_HW,
        W_OW
    } wb_op_t;

    typedef enum logic [1:0] {
        S_NONE,
        S_NET,
        S_OUT
    } sig_op_t;

    typedef struct packed {
        mul_op_t    mul_op;
        logic [1:0] mul_j;
        wb_op_t     wb_op;
        logic [2:0] wb_j;
        sig_op_t    sig_op;
        logic [1:0] sig_j;
        logic       load_in;
        logic       load_out;
    } mlp_cmd_t;

    // Shift-and-subtract division for the table math done at elaboration.
    // Both operands are nonnegative and the quotient fits in qbits bits.
    function automatic longint div_pos(longint n, longint d, int qbits);
        longint q;
        longint r;
        q = 0;
        r = n;
        for (int i = qbits - 1; i >= 0; i--) begin
            if ((r >>> i) >= d) begin
                r = r - (d <<< i);
                q = q | (64'sd1 <<< i);
            end
        end
        return q;
    endfunction

    // e^-f in Q30 for 0 <= f <= 1.0, by a 25-term series. Every term is
    // nonnegative, so dropping the Q30 scale first and then dividing by k
    // floors the same way as one combined division.
    function automatic longint exp_neg_q30(longint f);
        longint term;
        longint sum;
        term = Q30;
        sum  = Q30;
        for (int k = 1; k <= 24; k++) begin
            term = div_pos((term * f) >>> 30, longint'(k), 31);
            if ((k % 2) == 1) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        return (sum < 0) ? 64'sd0 : sum;
    endfunction

    // Sigmoid points at x = -8 + 16k/SIG_ENTRIES, worked out at elaboration.
    function automatic sig_rom_t build_sig_rom();
        sig_rom_t r;
        longint   e1;
        longint   m;
        longint   mag;
        longint   ip;
        longint   e;
        longint   d;
        longint   q;
        logic     neg;
        e1 = exp_neg_q30(Q30);
        for (int k = 0; k <= SIG_ENTRIES; k++) begin
            m   = 16 * longint'(k) - 8 * longint'(SIG_ENTRIES);
            neg = (m < 0);
            mag = neg ? -m : m;
            ip  = mag / SIG_ENTRIES;
            e   = exp_neg_q30(((mag % SIG_ENTRIES) <<< 30) / SIG_ENTRIES);
            for (longint i = 0; i < ip; i++) begin
                e = (e * e1) >>> 30;
            end
            d = Q30 + e;
            q = div_pos((ONE_FX <<< 30) + (d >>> 1), d, 18);
            r[k] = ROM_W'(neg ? (ONE_FX - q) : q);
        end
        return r;
    endfunction

    localparam sig_rom_t SIG_ROM = build_sig_rom();

    function automatic logic signed [W_W-1:0] tenths_fx(int tenths);
        return W_W'(div_pos(longint'(tenths) * ONE_FX + 5, 64'sd10, 24));
    endfunction

    localparam logic signed [W_W-1:0] HW_INIT [0:5] = '{
        tenths_fx(8), tenths_fx(4), tenths_fx(3),
        tenths_fx(2), tenths_fx(9), tenths_fx(5)
    };
    localparam logic signed [W_W-1:0] OW_INIT [0:2] = '{
        tenths_fx(3), tenths_fx(5), tenths_fx(9)
    };

    function automatic logic signed [W_W-1:0] sat32(logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        hi = ACC_W'(64'sh7FFF_FFFF);
        lo = -hi - ACC_W'(1);
        if (v > hi) begin
            return hi[W_W-1:0];
        end else if (v < lo) begin
            return lo[W_W-1:0];
        end
        return v[W_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== design/mlp_sig.sv =====
// ---------------------------------------------------------------------------
// mlp_sig: table sigmoid
// Clamps to [-8, 8], reads two neighboring table points and interpolates.
// ---------------------------------------------------------------------------
`default_nettype none

module mlp_sig
    import mlp_pkg::*;
(
    input  wire logic signed [NET_W-1:0]     x,
    output      logic        [FRAC_BITS-1:0] s
);

    localparam logic signed [NET_W-1:0] HALF_SPAN = NET_W'(8) <<< FRAC_BITS;

    logic signed [NET_W-1:0]  xc;
    logic        [SIG_SPAN_W:0] u;
    logic        [SIG_IDX_W:0]  idx;
    logic        [SIG_IDX_W-1:0] idx_lo;
    logic        [SIG_FRAC_W-1:0] frac;
    logic        [ROM_W-1:0]  p0;
    logic        [ROM_W-1:0]  p1;
    logic        [ROM_W-1:0]  diff;
    logic        [ROM_W+SIG_FRAC_W-1:0] step;
    logic        [ROM_W:0]    sum;

    always_comb begin
        if (x > HALF_SPAN) begin
            xc = HALF_SPAN;
        end else if (x < -HALF_SPAN) begin
            xc = -HALF_SPAN;
        end else begin
            xc = x;
        end
        u      = (SIG_SPAN_W+1)'(xc + HALF_SPAN);
        idx    = u[SIG_SPAN_W:SIG_FRAC_W];
        idx_lo = idx[SIG_IDX_W-1:0];
        frac   = u[SIG_FRAC_W-1:0];
        p0     = SIG_ROM[(SIG_IDX_W+1)'(idx_lo)];
        p1     = SIG_ROM[(SIG_IDX_W+1)'(idx_lo) + (SIG_IDX_W+1)'(1)];
        diff   = p1 - p0;
        step   = (ROM_W+SIG_FRAC_W)'(diff) * (ROM_W+SIG_FRAC_W)'(frac);
        if (idx[SIG_IDX_W]) begin
            sum = (ROM_W+1)'(SIG_ROM[SIG_ENTRIES]);
        end else begin
            sum = (ROM_W+1)'(p0) + (ROM_W+1)'(step >> SIG_FRAC_W);
        end
        // Cap just below one.
        if (sum > (ROM_W+1)'((1 << FRAC_BITS) - 1)) begin
            s = '1;
        end else begin
            s = sum[FRAC_BITS-1:0];
        end
    end

endmodule

`default_nettype wire

// ===== design/mlp_ctrl.sv =====
// ---------------------------------------------------------------------------
// mlp_ctrl: sequencer for the perceptron unit
// Steps through the micro-op program and runs the stream handshakes.
// ---------------------------------------------------------------------------
`default_nettype none

module mlp_ctrl
    import mlp_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_tvalid,
    output      logic     s_tready,
    input  wire logic     s_kind,
    output      logic     m_tvalid,
    input  wire logic     m_tready,
    output      mlp_cmd_t cmd
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_HOLD = 3'b100
    } state_t;

    localparam logic [STEP_W-1:0] LAST_EVAL  = STEP_W'(11);
    localparam logic [STEP_W-1:0] LAST_TRAIN = STEP_W'(31);

    state_t            state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              kind_reg, kind_next;
    logic              out_valid_reg, out_valid_next;
    logic              last;
    logic              out_free;
    mlp_cmd_t          prog;

    function automatic mlp_cmd_t mk(mul_op_t mo, int mj, wb_op_t wo, int wj,
                                    sig_op_t so, int sj);
        mlp_cmd_t c;
        c.mul_op   = mo;
        c.mul_j    = 2'(mj);
        c.wb_op    = wo;
        c.wb_j     = 3'(wj);
        c.sig_op   = so;
        c.sig_j    = 2'(sj);
        c.load_in  = 1'b0;
        c.load_out = 1'b0;
        return c;
    endfunction

    // Micro-op program: a step issues at most one multiply and retires at most
    // the product of the step before.
    always_comb begin
        case (step_reg)
            5'd0:  prog = mk(M_A_HW,      0, W_NONE,    0, S_NONE, 0);
            5'd1:  prog = mk(M_B_HW,      0, W_NET_SET, 0, S_NONE, 0);
            5'd2:  prog = mk(M_A_HW,      1, W_NET_ADD, 0, S_NONE, 0);
            5'd3:  prog = mk(M_B_HW,      1, W_NET_SET, 1, S_NET,  0);
            5'd4:  prog = mk(M_A_HW,      2, W_NET_ADD, 1, S_NONE, 0);
            5'd5:  prog = mk(M_B_HW,      2, W_NET_SET, 2, S_NET,  1);
            5'd6:  prog = mk(M_ACT_OW,    0, W_NET_ADD, 2, S_NONE, 0);
            5'd7:  prog = mk(M_ACT_OW,    1, W_O_SET,   0, S_NET,  2);
            5'd8:  prog = mk(M_ACT_OW,    2, W_O_ADD,   0, S_NONE, 0);
            5'd9:  prog = mk(M_NONE,      0, W_O_ADD,   0, S_NONE, 0);
            5'd10: prog = mk(M_NONE,      0, W_NONE,    0, S_OUT,  0);
            5'd11: prog = mk(M_SLOPE_O,   0, W_NONE,    0, S_NONE, 0);
            5'd12: prog = mk(M_ACT_SL,    0, W_SLOPE_O, 0, S_NONE, 0);
            5'd13: prog = mk(M_SLOPE_ERR, 0, W_SLH,     0, S_NONE, 0);
            5'd14: prog = mk(M_ACT_SL,    1, W_DOUT,    0, S_NONE, 0);
            5'd15: prog = mk(M_ACT_SL,    2, W_SLH,     1, S_NONE, 0);
            5'd16: prog = mk(M_DOUT_OW,   0, W_SLH,     2, S_NONE, 0);
            5'd17: prog = mk(M_DOUT_OW,   1, W_T,       0, S_NONE, 0);
            5'd18: prog = mk(M_DOUT_OW,   2, W_T,       1, S_NONE, 0);
            5'd19: prog = mk(M_T_SL,      0, W_T,       2, S_NONE, 0);
            5'd20: prog = mk(M_T_SL,      1, W_DH,      0, S_NONE, 0);
            5'd21: prog = mk(M_T_SL,      2, W_DH,      1, S_NONE, 0);
            5'd22: prog = mk(M_DH_A,      0, W_DH,      2, S_NONE, 0);
            5'd23: prog = mk(M_DH_B,      0, W_HW,      0, S_NONE, 0);
            5'd24: prog = mk(M_DH_A,      1, W_HW,      3, S_NONE, 0);
            5'd25: prog = mk(M_DH_B,      1, W_HW,      1, S_NONE, 0);
            5'd26: prog = mk(M_DH_A,      2, W_HW,      4, S_NONE, 0);
            5'd27: prog = mk(M_DH_B,      2, W_HW,      2, S_NONE, 0);
            5'd28: prog = mk(M_DOUT_ACT,  0, W_HW,      5, S_NONE, 0);
            5'd29: prog = mk(M_DOUT_ACT,  1, W_OW,      0, S_NONE, 0);
            5'd30: prog = mk(M_DOUT_ACT,  2, W_OW,      1, S_NONE, 0);
            5'd31: prog = mk(M_NONE,      0, W_OW,      2, S_NONE, 0);
            default: prog = mk(M_NONE,    0, W_NONE,    0, S_NONE, 0);
        endcase
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign last     = kind_reg ? (step_reg == LAST_TRAIN) : (step_reg == LAST_EVAL);
    assign out_free = !out_valid_reg || m_tready;

    always_comb begin
        state_next     = state_reg;
        step_next      = step_reg;
        kind_next      = kind_reg;
        out_valid_next = out_valid_reg;
        cmd            = mk(M_NONE, 0, W_NONE, 0, S_NONE, 0);
        if (m_tready) begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    kind_next   = s_kind;
                    step_next   = '0;
                    state_next  = ST_RUN;
                end
            end
            ST_RUN: begin
                cmd       = prog;
                step_next = step_reg + STEP_W'(1);
                if (last) begin
                    if (out_free) begin
                        cmd.load_out   = 1'b1;
                        out_valid_next = 1'b1;
                        state_next     = ST_IDLE;
                    end else begin
                        state_next = ST_HOLD;
                    end
                end
            end
            ST_HOLD: begin
                if (out_free) begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            kind_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            kind_reg      <= kind_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/mlp_dp.sv =====
// ---------------------------------------------------------------------------
// mlp_dp: datapath of the perceptron unit
// Weight registers, one shared multiplier, the sigmoid table and the
// registers that carry intermediate values between micro-ops.
// ---------------------------------------------------------------------------
`default_nettype none

module mlp_dp
    import mlp_pkg::*;
(
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire mlp_cmd_t                 cmd,
    input  wire logic signed [7:0]        in_a,
    input  wire logic signed [7:0]        in_b,
    input  wire logic                     target,
    output      logic [FRAC_BITS-1:0]     answer,
    output      logic signed [ERR_W-1:0]  error
);

    localparam logic [FRAC_BITS:0] ONE_U = (FRAC_BITS+1)'(1) << FRAC_BITS;
    localparam logic signed [PROD_W-1:0] RND =
        PROD_W'(1) <<< (FRAC_BITS - 1);

    logic signed [7:0]        a_reg, b_reg;
    logic                     tgt_reg;
    logic signed [W_W-1:0]    hw_reg [0:5];
    logic signed [W_W-1:0]    ow_reg [0:2];
    logic signed [NET_W-1:0]  net_reg [0:2];
    logic [FRAC_BITS-1:0]     act_reg [0:2];
    logic [FRAC_BITS-1:0]     slh_reg [0:2];
    logic signed [OP_W-1:0]   t_reg [0:2];
    logic signed [OP_W-1:0]   dh_reg [0:2];
    logic signed [O_W-1:0]    o_reg;
    logic [FRAC_BITS-1:0]     so_reg;
    logic signed [ERR_W-1:0]  err_reg;
    logic [FRAC_BITS-1:0]     slope_reg;
    logic signed [DOUT_W-1:0] dout_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic [FRAC_BITS-1:0]     answer_reg;
    logic signed [ERR_W-1:0]  error_reg;

    logic signed [OP_W-1:0]   ma, mb;
    logic signed [PROD_W-1:0] rnd;
    logic signed [NET_W-1:0]  sig_x;
    logic [FRAC_BITS-1:0]     sig_s;
    logic [2:0]               hj;
    logic signed [ACC_W-1:0]  hw_sum, ow_sum;

    mlp_sig u_sig (
        .x (sig_x),
        .s (sig_s)
    );

    assign answer = answer_reg;
    assign error  = error_reg;
    assign rnd    = (prod_reg + RND) >>> FRAC_BITS;
    assign hj     = 3'(cmd.mul_j) + 3'd3;
    assign hw_sum = ACC_W'(hw_reg[cmd.wb_j]) + ACC_W'(prod_reg);
    assign ow_sum = ACC_W'(ow_reg[cmd.wb_j[1:0]]) + ACC_W'(rnd);

    always_comb begin
        ma = '0;
        mb = '0;
        case (cmd.mul_op)
            M_A_HW: begin
                ma = OP_W'(a_reg);
                mb = OP_W'(hw_reg[3'(cmd.mul_j)]);
            end
            M_B_HW: begin
                ma = OP_W'(b_reg);
                mb = OP_W'(hw_reg[hj]);
            end
            M_ACT_OW: begin
                ma = OP_W'({1'b0, act_reg[cmd.mul_j]});
                mb = OP_W'(ow_reg[cmd.mul_j]);
            end
            M_SLOPE_O: begin
                ma = OP_W'({1'b0, so_reg});
                mb = OP_W'({1'b0, ONE_U - (FRAC_BITS+1)'(so_reg)});
            end
            M_SLOPE_ERR: begin
                ma = OP_W'({1'b0, slope_reg});
                mb = OP_W'(err_reg);
            end
            M_ACT_SL: begin
                ma = OP_W'({1'b0, act_reg[cmd.mul_j]});
                mb = OP_W'({1'b0, ONE_U - (FRAC_BITS+1)'(act_reg[cmd.mul_j])});
            end
            M_DOUT_OW: begin
                ma = OP_W'(dout_reg);
                mb = OP_W'(ow_reg[cmd.mul_j]);
            end
            M_T_SL: begin
                ma = t_reg[cmd.mul_j];
                mb = OP_W'({1'b0, slh_reg[cmd.mul_j]});
            end
            M_DH_A: begin
                ma = dh_reg[cmd.mul_j];
                mb = OP_W'(a_reg);
            end
            M_DH_B: begin
                ma = dh_reg[cmd.mul_j];
                mb = OP_W'(b_reg);
            end
            M_DOUT_ACT: begin
                ma = OP_W'(dout_reg);
                mb = OP_W'({1'b0, act_reg[cmd.mul_j]});
            end
            default: begin
                ma = '0;
                mb = '0;
            end
        endcase
    end

    always_comb begin
        case (cmd.sig_op)
            S_NET:   sig_x = net_reg[cmd.sig_j];
            S_OUT:   sig_x = NET_W'(o_reg);
            default: sig_x = '0;
        endcase
    end

    // Weights: cleared to their starting values by reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 6; i++) begin
                hw_reg[i] <= HW_INIT[i];
            end
            for (int i = 0; i < 3; i++) begin
                ow_reg[i] <= OW_INIT[i];
            end
        end else begin
            if (cmd.wb_op == W_HW) begin
                hw_reg[cmd.wb_j] <= sat32(hw_sum);
            end
            if (cmd.wb_op == W_OW) begin
                ow_reg[cmd.wb_j[1:0]] <= sat32(ow_sum);
            end
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= ma * mb;
        if (cmd.load_in) begin
            a_reg   <= in_a;
            b_reg   <= in_b;
            tgt_reg <= target;
        end
        if (cmd.load_out) begin
            answer_reg <= so_reg;
            error_reg  <= err_reg;
        end
        case (cmd.sig_op)
            S_NET: begin
                act_reg[cmd.sig_j] <= sig_s;
            end
            S_OUT: begin
                so_reg  <= sig_s;
                err_reg <= (tgt_reg ? (ERR_W'(1) <<< FRAC_BITS) : ERR_W'(0))
                           - ERR_W'({1'b0, sig_s});
            end
            default: begin
            end
        endcase
        case (cmd.wb_op)
            W_NET_SET: net_reg[cmd.wb_j[1:0]] <= prod_reg[NET_W-1:0];
            W_NET_ADD: net_reg[cmd.wb_j[1:0]] <= net_reg[cmd.wb_j[1:0]]
                                                 + prod_reg[NET_W-1:0];
            W_O_SET:   o_reg <= rnd[O_W-1:0];
            W_O_ADD:   o_reg <= o_reg + rnd[O_W-1:0];
            W_SLOPE_O: slope_reg <= prod_reg[2*FRAC_BITS-1:FRAC_BITS];
            W_SLH:     slh_reg[cmd.wb_j[1:0]] <= prod_reg[2*FRAC_BITS-1:FRAC_BITS];
            W_DOUT:    dout_reg <= rnd[DOUT_W-1:0];
            W_T:       t_reg[cmd.wb_j[1:0]] <= rnd[OP_W-1:0];
            W_DH:      dh_reg[cmd.wb_j[1:0]] <= rnd[OP_W-1:0];
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== design/mlp_2_3_1_backprop_step_unit.sv =====
// ---------------------------------------------------------------------------
// mlp_2_3_1_backprop_step_unit: 2-3-1 sigmoid perceptron with one-step
// backpropagation training
// One item is in work at a time; the next item is taken only after the result
// of the last one is loaded into the result register. Every dependent product
// of the item passes through the single shared multiplier.
// Reset (aresetn low, synchronous) loads the starting weights and clears the
// result valid flag; no clearing pass is needed.
// ---------------------------------------------------------------------------
`default_nettype none

module mlp_2_3_1_backprop_step_unit
    import mlp_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output      logic        s_tready,
    input  wire logic [23:0] s_tdata,   // in_a[7:0], in_b[15:8], target[16], zero pad
    input  wire logic [0:0]  s_tuser,   // kind[0]: 0 evaluate, 1 evaluate and train
    output      logic        m_tvalid,
    input  wire logic        m_tready,
    output      logic [39:0] m_tdata    // answer[15:0], error[33:16], zero pad
);

    // The controller walks a fixed micro-op program; a step issues at most one
    // multiply in the datapath and retires at most the product of the step before.
    // The result register sits in the datapath, so a finished result waits
    // there while the controller returns to idle and takes the next item.

    mlp_cmd_t                cmd;
    logic [FRAC_BITS-1:0]    answer;
    logic signed [ERR_W-1:0] error;

    mlp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_kind   (s_tuser[0]),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    mlp_dp u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .in_a    (s_tdata[7:0]),
        .in_b    (s_tdata[15:8]),
        .target  (s_tdata[16]),
        .answer  (answer),
        .error   (error)
    );

    // Results are Q0.16 and signed Q2.16 already since the datapath uses 16
    // fraction bits.
    assign m_tdata = {6'd0, error, answer};

endmodule

`default_nettype wire
